>>> rtl/text_cell_oled_page_renderer_unit_defines.svh
// Assertion macros used by the page renderer datapath.
`ifndef TEXT_CELL_OLED_PAGE_RENDERER_UNIT_DEFINES_SVH
`define TEXT_CELL_OLED_PAGE_RENDERER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TCOPR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("page renderer check failed");

// Next-cycle implication, checked outside reset.
`define TCOPR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("page renderer check failed");

`endif

>>> rtl/tcopr_pkg.sv
// Shared constants, font and controller/datapath interface types for the page renderer.
package tcopr_pkg;

   // display geometry
   localparam int DISPLAY_WIDTH  = 128;
   localparam int DISPLAY_HEIGHT = 64;
   localparam int PAGE_COUNT     = DISPLAY_HEIGHT / 8;
   localparam int PAGE_W         = $clog2(PAGE_COUNT);

   // frame memory: linear byte space, stored as 8-byte words
   localparam int WORD_COUNT = DISPLAY_WIDTH * PAGE_COUNT / 8;
   localparam int WORD_AW    = $clog2(WORD_COUNT);
   localparam int BYTE_AW    = WORD_AW + 3;
   // word pointer is kept as index+1 so the word before address zero is representable
   localparam int PTR_W      = $clog2(WORD_COUNT + 2);

   // text cells
   localparam int TEXT_COLUMNS = 21;
   localparam int CELL_WIDTH   = 6;

   // page stream: control byte plus one page of pixels
   localparam int STREAM_BYTES = DISPLAY_WIDTH + 1;
   localparam int DATA_BEATS   = (STREAM_BYTES + 7) / 8;
   localparam int BEAT_W       = $clog2(DATA_BEATS);
   localparam int REM_W        = $clog2(STREAM_BYTES + 1);

   // controller bytes
   localparam logic [7:0] CMD_CTRL     = 8'h00;
   localparam logic [7:0] PAGE_CMD     = 8'hB0;
   localparam logic [7:0] COL_HIGH_CMD = 8'h10;
   localparam logic [7:0] DATA_CTRL    = 8'h40;

   // operation codes
   localparam logic [1:0] OP_DRAW  = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic clear_all;
      logic draw_wr;
      logic draw_next;
      logic ld_setup;
      logic ld_data;
      logic prev_load;
      logic ptr_inc;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic draw_ok;
      logic clear_ok;
      logic flush_ok;
      logic out_free;
      logic last_beat;
   } status_type;

   // pack five glyph columns, first column in the low byte
   function automatic logic [39:0] glyph5(input logic [7:0] c0, input logic [7:0] c1,
                                          input logic [7:0] c2, input logic [7:0] c3,
                                          input logic [7:0] c4);
      return {c4, c3, c2, c1, c0};
   endfunction

   // 5x7 font; unknown codes are blank
   function automatic logic [39:0] glyph_bits(input logic [7:0] code);
      logic [39:0] g;
      unique case (code)
         8'h30: g = glyph5(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
         8'h31: g = glyph5(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
         8'h32: g = glyph5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
         8'h33: g = glyph5(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
         8'h34: g = glyph5(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
         8'h35: g = glyph5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
         8'h36: g = glyph5(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
         8'h37: g = glyph5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
         8'h38: g = glyph5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
         8'h39: g = glyph5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
         8'h41: g = glyph5(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
         8'h42: g = glyph5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
         8'h43: g = glyph5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
         8'h44: g = glyph5(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
         8'h45: g = glyph5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
         8'h46: g = glyph5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
         8'h47: g = glyph5(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
         8'h48: g = glyph5(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
         8'h49: g = glyph5(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
         8'h4A: g = glyph5(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
         8'h4B: g = glyph5(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
         8'h4C: g = glyph5(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
         8'h4D: g = glyph5(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
         8'h4E: g = glyph5(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
         8'h4F: g = glyph5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
         8'h50: g = glyph5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
         8'h51: g = glyph5(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
         8'h52: g = glyph5(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
         8'h53: g = glyph5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
         8'h54: g = glyph5(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
         8'h55: g = glyph5(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
         8'h56: g = glyph5(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
         8'h57: g = glyph5(8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F);
         8'h58: g = glyph5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
         8'h59: g = glyph5(8'h03, 8'h04, 8'h78, 8'h04, 8'h03);
         8'h5A: g = glyph5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
         8'h2E: g = glyph5(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
         8'h3A: g = glyph5(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
         8'h2D: g = glyph5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
         8'h2F: g = glyph5(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);
         8'h25: g = glyph5(8'h62, 8'h64, 8'h08, 8'h13, 8'h23);
         8'h3E: g = glyph5(8'h08, 8'h14, 8'h22, 8'h41, 8'h00);
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

>>> rtl/tcopr_ctrl.sv
// Sequencer for draw, clear and flush operations of the page renderer.
module tcopr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tcopr_pkg::status_type status,
   output tcopr_pkg::cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DRD0   = 4'd1;
   localparam logic [3:0] ST_DWR0   = 4'd2;
   localparam logic [3:0] ST_DRD1   = 4'd3;
   localparam logic [3:0] ST_DWR1   = 4'd4;
   localparam logic [3:0] ST_FSETUP = 4'd5;
   localparam logic [3:0] ST_FLOW   = 4'd6;
   localparam logic [3:0] ST_FWAIT  = 4'd7;
   localparam logic [3:0] ST_FDATA  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // one operation at a time
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.clear_all = status.clear_ok;
               if (status.draw_ok) begin
                  state_in = ST_DRD0;
               end else if (status.flush_ok) begin
                  state_in = ST_FSETUP;
               end
            end
         end
         ST_DRD0: begin
            state_in = ST_DWR0;
         end
         ST_DWR0: begin
            cmd.draw_wr   = 1'b1;
            cmd.draw_next = 1'b1;
            state_in      = ST_DRD1;
         end
         ST_DRD1: begin
            state_in = ST_DWR1;
         end
         ST_DWR1: begin
            cmd.draw_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_FSETUP: begin
            if (status.out_free) begin
               cmd.ld_setup = 1'b1;
               state_in     = ST_FLOW;
            end
         end
         ST_FLOW: begin
            cmd.prev_load = 1'b1;
            cmd.ptr_inc   = 1'b1;
            state_in      = ST_FWAIT;
         end
         ST_FWAIT: begin
            state_in = ST_FDATA;
         end
         ST_FDATA: begin
            if (status.out_free) begin
               cmd.ld_data   = 1'b1;
               cmd.prev_load = 1'b1;
               cmd.ptr_inc   = 1'b1;
               state_in      = status.last_beat ? ST_IDLE : ST_FWAIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/tcopr_dp.sv
// Frame memory, glyph merge, page stream assembly and result register.
`include "text_cell_oled_page_renderer_unit_defines.svh"

module tcopr_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_operation,
   input  logic [3:0]            req_line,
   input  logic [4:0]            req_column,
   input  logic [7:0]            req_char_code,
   input  tcopr_pkg::cmd_type    cmd,
   output tcopr_pkg::status_type status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [63:0]           rsp_payload,
   output logic [3:0]            rsp_byte_count,
   output logic                  rsp_transfer_start,
   output logic                  rsp_transfer_end,
   output logic                  rsp_last
);

   // frame memory and per-word valid bits (invalid word reads as zero)
   logic [63:0] frame_mem_ff [tcopr_pkg::WORD_COUNT];
   logic [tcopr_pkg::WORD_COUNT-1:0] valid_ff;
   logic [63:0] rd_word_ff;
   logic        rd_vld_ff;
   logic [63:0] rd_data;

   // operation context
   logic [tcopr_pkg::BYTE_AW-1:0] base_ff;
   logic [39:0]                   glyph_ff;
   logic [tcopr_pkg::PAGE_W-1:0]  page_ff;
   logic [2:0]                    lane_ff;
   logic [tcopr_pkg::PTR_W-1:0]   ptr_ff;
   logic [tcopr_pkg::BEAT_W-1:0]  beat_ff;
   logic [63:0]                   prev_ff;

   // result register
   logic        out_vld_ff;
   logic [63:0] payload_ff;
   logic [3:0]  count_ff;
   logic        start_ff;
   logic        end_ff;
   logic        last_ff;

   logic                          line_ok;
   logic                          col_ok;
   logic [tcopr_pkg::PAGE_W-1:0]  req_page;
   logic [tcopr_pkg::BYTE_AW-1:0] page_base;
   logic [tcopr_pkg::BYTE_AW-1:0] cell_base;
   logic [tcopr_pkg::BYTE_AW-1:0] flush_anchor;
   logic [tcopr_pkg::BYTE_AW-1:0] cell_end;
   logic                          ptr_ok;
   logic [tcopr_pkg::PTR_W-1:0]   ptr_m1;
   logic [tcopr_pkg::WORD_AW-1:0] rd_idx;
   logic [63:0]                   merged;
   logic [127:0]                  window;
   logic [63:0]                   shifted;
   logic [tcopr_pkg::REM_W-1:0]   remain;
   logic [3:0]                    beat_count;
   logic [63:0]                   beat_payload;
   logic                          last_beat;

   // request decode
   assign line_ok  = (req_line < 4'(tcopr_pkg::PAGE_COUNT));
   assign col_ok   = (req_column < 5'(tcopr_pkg::TEXT_COLUMNS));
   assign req_page = req_line[tcopr_pkg::PAGE_W-1:0];

   assign status.draw_ok   = (req_operation == tcopr_pkg::OP_DRAW) && line_ok && col_ok;
   assign status.clear_ok  = (req_operation == tcopr_pkg::OP_CLEAR);
   assign status.flush_ok  = (req_operation == tcopr_pkg::OP_FLUSH) && line_ok;
   assign status.out_free  = !out_vld_ff || !rsp_stall;
   assign status.last_beat = last_beat;

   // byte addresses; flush anchor is one byte before the page, biased by a word
   assign page_base    = tcopr_pkg::BYTE_AW'(req_page)
                       * tcopr_pkg::BYTE_AW'(tcopr_pkg::DISPLAY_WIDTH);
   assign cell_base    = page_base + tcopr_pkg::BYTE_AW'(req_column)
                       * tcopr_pkg::BYTE_AW'(tcopr_pkg::CELL_WIDTH);
   assign flush_anchor = page_base + tcopr_pkg::BYTE_AW'(7);
   assign cell_end     = base_ff + tcopr_pkg::BYTE_AW'(tcopr_pkg::CELL_WIDTH - 1);

   // word pointer holds index+1; out-of-range words read as don't-care
   assign ptr_ok = (ptr_ff != '0) && (ptr_ff <= tcopr_pkg::PTR_W'(tcopr_pkg::WORD_COUNT));
   assign ptr_m1 = ptr_ff - tcopr_pkg::PTR_W'(1);
   assign rd_idx = ptr_ok ? ptr_m1[tcopr_pkg::WORD_AW-1:0] : '0;
   assign rd_data = rd_vld_ff ? rd_word_ff : '0;

   // context capture and pointer stepping
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         base_ff  <= cell_base;
         glyph_ff <= tcopr_pkg::glyph_bits(req_char_code);
         page_ff  <= req_page;
         lane_ff  <= flush_anchor[2:0];
         beat_ff  <= '0;
         if (req_operation == tcopr_pkg::OP_FLUSH) begin
            ptr_ff <= tcopr_pkg::PTR_W'(flush_anchor[tcopr_pkg::BYTE_AW-1:3]);
         end else begin
            ptr_ff <= tcopr_pkg::PTR_W'(cell_base[tcopr_pkg::BYTE_AW-1:3])
                    + tcopr_pkg::PTR_W'(1);
         end
      end else begin
         if (cmd.draw_next) begin
            ptr_ff <= tcopr_pkg::PTR_W'(cell_end[tcopr_pkg::BYTE_AW-1:3])
                    + tcopr_pkg::PTR_W'(1);
         end else if (cmd.ptr_inc) begin
            ptr_ff <= ptr_ff + tcopr_pkg::PTR_W'(1);
         end
         if (cmd.ld_data) begin
            beat_ff <= beat_ff + tcopr_pkg::BEAT_W'(1);
         end
      end
      if (cmd.prev_load) begin
         prev_ff <= rd_data;
      end
   end

   // glyph merge into the word just read: cell bytes take glyph or blank
   always_comb begin
      logic [tcopr_pkg::BYTE_AW-1:0] lane_addr;
      logic [tcopr_pkg::BYTE_AW-1:0] diff;
      merged = rd_data;
      for (int l = 0; l < 8; l++) begin
         lane_addr = {rd_idx, 3'(l)};
         diff      = lane_addr - base_ff;
         if (diff < tcopr_pkg::BYTE_AW'(tcopr_pkg::CELL_WIDTH)) begin
            case (diff[2:0])
               3'd0:    merged[8*l +: 8] = glyph_ff[7:0];
               3'd1:    merged[8*l +: 8] = glyph_ff[15:8];
               3'd2:    merged[8*l +: 8] = glyph_ff[23:16];
               3'd3:    merged[8*l +: 8] = glyph_ff[31:24];
               3'd4:    merged[8*l +: 8] = glyph_ff[39:32];
               default: merged[8*l +: 8] = 8'h00;
            endcase
         end
      end
   end

   // frame memory: one address for the registered read and the write
   always_ff @(posedge clock) begin
      if (cmd.draw_wr) begin
         frame_mem_ff[rd_idx] <= merged;
      end
      rd_word_ff <= frame_mem_ff[rd_idx];
   end

   // word valid bits; clear and reset empty the frame at once
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.clear_all) begin
            valid_ff <= '0;
         end else if (cmd.draw_wr) begin
            valid_ff[rd_idx] <= 1'b1;
         end
         rd_vld_ff <= valid_ff[rd_idx];
      end
   end

   // data beat: up to eight stream bytes from the previous and current word
   assign window  = {rd_data, prev_ff};
   assign shifted = 64'(window >> {lane_ff, 3'b000});
   assign remain  = tcopr_pkg::REM_W'(tcopr_pkg::STREAM_BYTES)
                  - tcopr_pkg::REM_W'({beat_ff, 3'b000});
   assign beat_count = (remain > tcopr_pkg::REM_W'(8)) ? 4'd8 : remain[3:0];
   assign last_beat  = (beat_ff == tcopr_pkg::BEAT_W'(tcopr_pkg::DATA_BEATS - 1));

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         beat_payload[8*k +: 8] = (4'(k) < beat_count) ? shifted[8*k +: 8] : 8'h00;
      end
      if (beat_ff == '0) begin
         beat_payload[7:0] = tcopr_pkg::DATA_CTRL;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.ld_setup || cmd.ld_data) begin
         out_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_setup) begin
         payload_ff <= {32'h0, tcopr_pkg::COL_HIGH_CMD, 8'h00,
                        tcopr_pkg::PAGE_CMD + 8'(page_ff), tcopr_pkg::CMD_CTRL};
         count_ff   <= 4'd4;
         start_ff   <= 1'b1;
         end_ff     <= 1'b1;
         last_ff    <= 1'b0;
      end else if (cmd.ld_data) begin
         payload_ff <= beat_payload;
         count_ff   <= beat_count;
         start_ff   <= (beat_ff == '0);
         end_ff     <= last_beat;
         last_ff    <= last_beat;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_payload        = payload_ff;
   assign rsp_byte_count     = count_ff;
   assign rsp_transfer_start = start_ff;
   assign rsp_transfer_end   = end_ff;
   assign rsp_last           = last_ff;

   `TCOPR_ASSERT_IMP(a_load_when_free, clock, reset, cmd.ld_setup || cmd.ld_data, !out_vld_ff || !rsp_stall)
   `TCOPR_ASSERT_IMP(a_write_in_range, clock, reset, cmd.draw_wr, ptr_ok)
   `TCOPR_ASSERT_NXT(a_clear_empties, clock, reset, cmd.clear_all, valid_ff == '0)
   `TCOPR_ASSERT_NXT(a_first_beat_ctrl, clock, reset, cmd.ld_data && (beat_ff == '0), rsp_transfer_start && (rsp_payload[7:0] == tcopr_pkg::DATA_CTRL))

endmodule

>>> rtl/text_cell_oled_page_renderer_unit.sv
// Top level of the page-organized OLED text renderer.
// Holds a 128x64 monochrome frame (eight pages of 128 bytes) drawn with a 5x7 font in
// 21x8 text cells, and streams one page per flush as a 4-byte page-setup beat followed
// by the 0x40 control byte and the page's bytes in beats of up to eight bytes (17 beats
// at 128 columns). Operations run one at a time: a draw makes two read-merge-write
// passes over the single-port frame memory, a clear drops the per-word valid bits (so no
// sweep is needed after reset or clear), and a flush sends the setup beat and then the
// data beats, each of which needs one registered word read. A finished beat waits in
// the result register while the next one is fetched.
module text_cell_oled_page_renderer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [3:0]  req_line,
   input  logic [4:0]  req_column,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_payload,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_transfer_start,
   output logic        rsp_transfer_end,
   output logic        rsp_last
);

   tcopr_pkg::cmd_type    cmd;
   tcopr_pkg::status_type status;

   // sequencer
   tcopr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // frame memory and stream datapath
   tcopr_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_operation      (req_operation),
      .req_line           (req_line),
      .req_column         (req_column),
      .req_char_code      (req_char_code),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload        (rsp_payload),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_transfer_start (rsp_transfer_start),
      .rsp_transfer_end   (rsp_transfer_end),
      .rsp_last           (rsp_last)
   );

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the OLED page renderer: draws, clears and page flushes.
`timescale 1ns / 1ps

module tb;

   localparam logic [1:0] OP_NOP = 2'd3;   // unused code, block must ignore it

   localparam int ITEM_TARGET   = 410;
   localparam int PRESSURE_HOLD = 400;
   localparam int IDLE_LIMIT    = 4000;
   localparam int DRAIN_CYCLES  = 64;
   localparam int FRAME_BYTES   = tcopr_pkg::DISPLAY_WIDTH * tcopr_pkg::PAGE_COUNT;

   // glyph columns, first column in the top byte
   localparam logic [39:0] DIGIT_GLYPH [10] = '{
      40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
      40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
      40'h36_49_49_49_36, 40'h06_49_49_29_1E
   };
   localparam logic [39:0] LETTER_GLYPH [26] = '{
      40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22, 40'h7F_41_41_22_1C,
      40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A, 40'h7F_08_08_08_7F,
      40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41, 40'h7F_40_40_40_40,
      40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E, 40'h7F_09_09_09_06,
      40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31, 40'h01_01_7F_01_01,
      40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h7F_20_18_20_7F, 40'h63_14_08_14_63,
      40'h03_04_78_04_03, 40'h61_51_49_45_43
   };

   typedef struct {
      logic [63:0] payload;
      logic [3:0]  count;
      logic        start_flag;
      logic        end_flag;
      logic        last_flag;
   } page_beat_type;

   // Frame mirror plus the queue of beats that pending flushes owe
   class page_scoreboard;
      logic [7:0] frame [FRAME_BYTES];
      page_beat_type owed[$];
      int errors;
      int beats_checked;
      int draws, clears, flushes, ignored;

      function new();
         wipe();
      endfunction

      function void wipe();
         foreach (frame[i]) frame[i] = 8'h00;
      endfunction

      function logic [39:0] glyph_of(logic [7:0] code);
         if (code >= "0" && code <= "9") return DIGIT_GLYPH[code - "0"];
         if (code >= "A" && code <= "Z") return LETTER_GLYPH[code - "A"];
         case (code)
            ".":     return 40'h00_60_60_00_00;
            ":":     return 40'h00_36_36_00_00;
            "-":     return 40'h08_08_08_08_08;
            "/":     return 40'h20_10_08_04_02;
            "%":     return 40'h62_64_08_13_23;
            ">":     return 40'h08_14_22_41_00;
            default: return '0;
         endcase
      endfunction

      // setup beat, then 0x40 and the page bytes in beats of eight
      function void owe_page(logic [3:0] page);
         page_beat_type b;
         int total, pos, n, idx, base;
         b.payload    = {32'h0, tcopr_pkg::COL_HIGH_CMD, tcopr_pkg::CMD_CTRL,
                         tcopr_pkg::PAGE_CMD + {4'h0, page}, tcopr_pkg::CMD_CTRL};
         b.count      = 4'd4;
         b.start_flag = 1'b1;
         b.end_flag   = 1'b1;
         b.last_flag  = 1'b0;
         owed.push_back(b);
         total = tcopr_pkg::DISPLAY_WIDTH + 1;
         base  = int'(page) * tcopr_pkg::DISPLAY_WIDTH;
         for (pos = 0; pos < total; pos += 8) begin
            n = (total - pos > 8) ? 8 : total - pos;
            b.payload = '0;
            for (int j = 0; j < n; j++) begin
               idx = pos + j;
               b.payload[8*j +: 8] = (idx == 0) ? tcopr_pkg::DATA_CTRL
                                                : frame[base + idx - 1];
            end
            b.count      = 4'(n);
            b.start_flag = (pos == 0);
            b.end_flag   = (pos + n == total);
            b.last_flag  = (pos + n == total);
            owed.push_back(b);
         end
      endfunction

      // apply one accepted request to the mirror and the owed beats
      function void note_request(logic [1:0] op, logic [3:0] line, logic [4:0] col,
                                 logic [7:0] code);
         logic [39:0] g;
         int base;
         if (op == tcopr_pkg::OP_DRAW && line < tcopr_pkg::PAGE_COUNT
             && col < tcopr_pkg::TEXT_COLUMNS) begin
            g    = glyph_of(code);
            base = int'(line) * tcopr_pkg::DISPLAY_WIDTH + int'(col) * tcopr_pkg::CELL_WIDTH;
            for (int i = 0; i < 5; i++) frame[base + i] = g[39 - 8*i -: 8];
            frame[base + 5] = 8'h00;
            draws++;
            return;
         end
         if (op == tcopr_pkg::OP_CLEAR) begin
            wipe();
            clears++;
            return;
         end
         if (op == tcopr_pkg::OP_FLUSH && line < tcopr_pkg::PAGE_COUNT) begin
            owe_page(line);
            flushes++;
            return;
         end
         ignored++;
      endfunction

      task report(string field, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("MISMATCH beat %0d %s: got %h want %h", beats_checked, field, got, want);
      endtask

      task check_beat(page_beat_type got);
         page_beat_type want;
         beats_checked++;
         if (owed.size() == 0) begin
            report("unexpected beat", got.payload, 64'h0);
            return;
         end
         want = owed.pop_front();
         if (got.payload !== want.payload) report("payload", got.payload, want.payload);
         if (got.count !== want.count) report("byte_count", 64'(got.count), 64'(want.count));
         if (got.start_flag !== want.start_flag)
            report("transfer_start", 64'(got.start_flag), 64'(want.start_flag));
         if (got.end_flag !== want.end_flag)
            report("transfer_end", 64'(got.end_flag), 64'(want.end_flag));
         if (got.last_flag !== want.last_flag)
            report("last", 64'(got.last_flag), 64'(want.last_flag));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_operation;
   logic [3:0]  req_line;
   logic [4:0]  req_column;
   logic [7:0]  req_char_code;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_payload;
   logic [3:0]  rsp_byte_count;
   logic        rsp_transfer_start;
   logic        rsp_transfer_end;
   logic        rsp_last;

   page_scoreboard sb = new;
   int items_sent    = 0;
   int beats_seen    = 0;
   int send_calm     = 0;
   bit hold_done     = 1'b0;
   int hold_backlog  = 0;

   text_cell_oled_page_renderer_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_line           (req_line),
      .req_column         (req_column),
      .req_char_code      (req_char_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload        (rsp_payload),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_transfer_start (rsp_transfer_start),
      .rsp_transfer_end   (rsp_transfer_end),
      .rsp_last           (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pick_char();
      string glyph_set;
      glyph_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ.:-/%>";
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
      return glyph_set[$urandom_range(0, glyph_set.len() - 1)];
   endfunction

   // one request beat: idle gap with junk fields, then hold until taken
   task automatic send_req(logic [1:0] op, logic [3:0] line, logic [4:0] col,
                           logic [7:0] code);
      int gap;
      if (send_calm > 0) begin
         send_calm--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 24) == 0) send_calm = $urandom_range(10, 40);
         gap = pick_idle();
      end
      @(negedge clock);
      repeat (gap) begin
         req_valid     = 1'b0;
         req_operation = 2'($urandom_range(0, 3));
         req_line      = 4'($urandom_range(0, 15));
         req_column    = 5'($urandom_range(0, 31));
         req_char_code = 8'($urandom_range(0, 255));
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_operation = op;
      req_line      = line;
      req_column    = col;
      req_char_code = code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, line, col, code);
      items_sent++;
   endtask

   // text writes followed by page flushes, as a display driver would issue them
   task automatic screen_update();
      int n;
      if ($urandom_range(0, 4) == 0)
         send_req(tcopr_pkg::OP_CLEAR, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                  8'($urandom_range(0, 255)));
      n = $urandom_range(2, 10);
      repeat (n)
         send_req(tcopr_pkg::OP_DRAW, 4'($urandom_range(0, tcopr_pkg::PAGE_COUNT - 1)),
                  5'($urandom_range(0, tcopr_pkg::TEXT_COLUMNS - 1)), pick_char());
      if ($urandom_range(0, 1) == 1) begin
         for (int p = 0; p < tcopr_pkg::PAGE_COUNT; p++)
            send_req(tcopr_pkg::OP_FLUSH, 4'(p), 5'($urandom_range(0, 31)),
                     8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 2))
            send_req(tcopr_pkg::OP_FLUSH, 4'($urandom_range(0, tcopr_pkg::PAGE_COUNT - 1)),
                     5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic noise_items();
      repeat ($urandom_range(1, 4))
         send_req(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                  5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
   endtask

   // receiver: random stall pattern, one long hold once traffic is flowing
   initial begin : rsp_side
      int stall_left;
      int free_left;
      stall_left = 0;
      free_left  = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && beats_seen >= 200) begin
            hold_done  = 1'b1;
            stall_left = PRESSURE_HOLD;
            free_left  = 0;
         end
         if (stall_left == 0 && free_left == 0) begin
            if ($urandom_range(0, 19) == 0) begin
               free_left = $urandom_range(20, 60);
            end else begin
               free_left  = $urandom_range(1, 6);
               stall_left = pick_idle();
            end
         end
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
            if (stall_left == 0 && hold_done && hold_backlog == 0)
               hold_backlog = sb.owed.size();
         end else begin
            rsp_stall = 1'b0;
            free_left--;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      page_beat_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.payload    = rsp_payload;
         got.count      = rsp_byte_count;
         got.start_flag = rsp_transfer_start;
         got.end_flag   = rsp_transfer_end;
         got.last_flag  = rsp_last;
         sb.check_beat(got);
         beats_seen++;
      end
   end

   // watchdog on cycles without any beat accepted
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = tcopr_pkg::OP_DRAW;
      req_line      = 4'd0;
      req_column    = 5'd0;
      req_char_code = 8'd0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty page, font classes, cell extremes, out-of-range and unused codes
      send_req(tcopr_pkg::OP_FLUSH, 4'd0, 5'd0, 8'h00);
      send_req(tcopr_pkg::OP_DRAW, 4'd0, 5'd0, "0");
      send_req(tcopr_pkg::OP_DRAW, 4'd7, 5'd20, "Z");
      send_req(tcopr_pkg::OP_DRAW, 4'd3, 5'd5, ".");
      send_req(tcopr_pkg::OP_DRAW, 4'd3, 5'd6, ":");
      send_req(tcopr_pkg::OP_DRAW, 4'd3, 5'd7, "-");
      send_req(tcopr_pkg::OP_DRAW, 4'd3, 5'd8, "/");
      send_req(tcopr_pkg::OP_DRAW, 4'd3, 5'd9, "%");
      send_req(tcopr_pkg::OP_DRAW, 4'd3, 5'd10, ">");
      send_req(tcopr_pkg::OP_DRAW, 4'd0, 5'd1, "a");
      send_req(tcopr_pkg::OP_DRAW, 4'd0, 5'd2, 8'hFF);
      send_req(tcopr_pkg::OP_DRAW, 4'd7, 5'd19, 8'h00);
      send_req(tcopr_pkg::OP_DRAW, 4'd8, 5'd0, "A");
      send_req(tcopr_pkg::OP_DRAW, 4'd15, 5'd31, "A");
      send_req(tcopr_pkg::OP_DRAW, 4'd0, 5'd21, "B");
      send_req(OP_NOP, 4'd15, 5'd31, 8'hFF);
      send_req(tcopr_pkg::OP_FLUSH, 4'd0, 5'd31, 8'hFF);
      send_req(tcopr_pkg::OP_FLUSH, 4'd3, 5'd0, 8'h00);
      send_req(tcopr_pkg::OP_FLUSH, 4'd7, 5'd0, 8'h00);
      send_req(tcopr_pkg::OP_FLUSH, 4'd8, 5'd0, 8'h00);
      send_req(tcopr_pkg::OP_FLUSH, 4'd15, 5'd0, 8'h00);
      send_req(tcopr_pkg::OP_DRAW, 4'd0, 5'd0, "M");
      send_req(tcopr_pkg::OP_CLEAR, 4'd15, 5'd31, 8'hFF);
      send_req(tcopr_pkg::OP_FLUSH, 4'd7, 5'd0, 8'h00);
      send_req(tcopr_pkg::OP_FLUSH, 4'd0, 5'd0, 8'h00);

      // random: mostly screen updates, some junk requests
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) < 8) screen_update();
         else noise_items();
      end
      @(negedge clock);
      req_valid = 1'b0;

      while (sb.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d draws, %0d clears, %0d flushes, %0d ignored requests",
               sb.draws, sb.clears, sb.flushes, sb.ignored);
      $display("checked %0d result beats; %0d beats backed up behind the long output hold",
               sb.beats_checked, hold_backlog);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> text_cell_oled_page_renderer_unit.f
+incdir+rtl
rtl/tcopr_pkg.sv
rtl/tcopr_ctrl.sv
rtl/tcopr_dp.sv
rtl/text_cell_oled_page_renderer_unit.sv
tb/sv/tb.sv
